// ===== rtl/core/differential_drive_odometry_assert.svh =====
// Assertion macros shared by the odometry checker.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DDO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");

// Checks that the consequent starts in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");

`endif

// ===== rtl/core/ddo_pkg.sv =====
// Shared types, constants and the CORDIC angle table of the odometry block.
package ddo_pkg;

    // Default configuration of the top level.
    localparam int DEFAULT_CORDIC_STEPS   = 24;
    localparam int DEFAULT_POSITION_WIDTH = 48;

    // Field and datapath widths.
    localparam int IN_W       = 18;
    localparam int IN_TDATA_W = 40;
    localparam int HEADING_W  = 32;
    localparam int DIFF_W     = 19;
    localparam int TRIG_W     = 33;
    localparam int MUL_B_W    = 34;
    localparam int PROD_W     = 53;
    localparam int DISP_W     = 22;
    localparam int ATAN_IDX_W = 5;

    // Reset value of the turn rate: wheel base of 0.467 m.
    localparam logic [HEADING_W-1:0] TURN_RESET = 32'd1463737207;

    // Gain-corrected unit vector length in Q30.
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // Rounding offsets for the heading change, the half change and the displacement.
    localparam logic signed [PROD_W-1:0] RND_DTH  = 53'sd32768;
    localparam logic signed [PROD_W-1:0] RND_HALF = 53'sd65536;
    localparam logic signed [PROD_W-1:0] RND_DISP = 53'sd1073741824;

    // Sequencer states.
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_MUL_TURN = 9'b000000010,
        S_ANGLE    = 9'b000000100,
        S_ROTATE   = 9'b000001000,
        S_MAP      = 9'b000010000,
        S_MUL_X    = 9'b000100000,
        S_MUL_Y    = 9'b001000000,
        S_ACC_Y    = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    // Arctangent of 2^-i as a binary angle, 2^32 per full turn.
    function automatic logic signed [TRIG_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [TRIG_W-1:0] val;
        case (idx)
            5'd0:  val = 33'sd536870912;
            5'd1:  val = 33'sd316933406;
            5'd2:  val = 33'sd167458907;
            5'd3:  val = 33'sd85004756;
            5'd4:  val = 33'sd42667331;
            5'd5:  val = 33'sd21354465;
            5'd6:  val = 33'sd10679838;
            5'd7:  val = 33'sd5340245;
            5'd8:  val = 33'sd2670163;
            5'd9:  val = 33'sd1335087;
            5'd10: val = 33'sd667544;
            5'd11: val = 33'sd333772;
            5'd12: val = 33'sd166886;
            5'd13: val = 33'sd83443;
            5'd14: val = 33'sd41722;
            5'd15: val = 33'sd20861;
            5'd16: val = 33'sd10430;
            5'd17: val = 33'sd5215;
            5'd18: val = 33'sd2608;
            5'd19: val = 33'sd1304;
            5'd20: val = 33'sd652;
            5'd21: val = 33'sd326;
            5'd22: val = 33'sd163;
            5'd23: val = 33'sd81;
            5'd24: val = 33'sd41;
            5'd25: val = 33'sd20;
            5'd26: val = 33'sd10;
            5'd27: val = 33'sd5;
            5'd28: val = 33'sd3;
            5'd29: val = 33'sd1;
            5'd30: val = 33'sd1;
            default: val = 33'sd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/differential_drive_odometry.sv =====
// Each item runs through S_MUL_TURN, S_ANGLE, the CORDIC rotations of S_ROTATE, S_MAP,
// S_MUL_X, S_MUL_Y, S_ACC_Y and S_DONE, one item at a time, before its result is registered.
// The CORDIC shift-add unit does one rotation per cycle and one shared multiplier is used
// three times. The next item is taken while a finished result waits in the output register.
// Reset (synchronous, active low) clears x, y and heading and loads the default turn rate.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS   = ddo_pkg::DEFAULT_CORDIC_STEPS,
    parameter int POSITION_WIDTH = ddo_pkg::DEFAULT_POSITION_WIDTH
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Input stream. tdata: left_distance [17:0], right_distance [35:18], zero fill.
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    input  logic [ddo_pkg::IN_TDATA_W-1:0]            i_s_tdata,
    // Result stream. tdata: pos_x, pos_y, heading from the lowest bit up, zero fill.
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    output logic [((2*POSITION_WIDTH+ddo_pkg::HEADING_W+7)/8)*8-1:0] o_m_tdata,
    // Configuration write channel: turn_per_distance.
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [ddo_pkg::HEADING_W-1:0]             i_cfg_data
);
    import ddo_pkg::*;

    localparam int OUT_W  = ((2*POSITION_WIDTH+HEADING_W+7)/8)*8;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS-1);
    localparam logic signed [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
    localparam logic signed [POSITION_WIDTH-1:0] POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};

    t_state                          r_state, n_state;
    logic [HEADING_W-1:0]            r_turn;
    logic [HEADING_W-1:0]            r_heading;
    logic signed [IN_W-1:0]          r_left, r_right;
    logic signed [POSITION_WIDTH-1:0] r_x, r_y;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [TRIG_W-1:0]        r_cx, r_cy, r_cz;
    logic [1:0]                      r_quad;
    logic [STEP_W-1:0]               r_step;
    logic [POSITION_WIDTH-1:0]       r_out_x, r_out_y;
    logic [HEADING_W-1:0]            r_out_h;
    logic                            r_m_tvalid;

    logic signed [DIFF_W-1:0]        w_diff, w_sum;
    logic signed [DIFF_W-1:0]        w_mul_a;
    logic signed [MUL_B_W-1:0]       w_mul_b;
    logic signed [PROD_W-1:0]        w_mul;
    logic signed [PROD_W-1:0]        w_dth_sum, w_half_sum, w_disp_sum;
    logic [HEADING_W-1:0]            w_dth, w_half, w_mid;
    logic signed [DISP_W-1:0]        w_disp;
    logic signed [POSITION_WIDTH-1:0] w_acc_in, w_sat;
    logic signed [POSITION_WIDTH:0]  w_sat_sum;
    logic signed [TRIG_W-1:0]        w_xs, w_ys, w_atan;
    logic signed [TRIG_W-1:0]        w_cos, w_sin;
    logic                            w_out_load;

    // Handshake outputs.
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = OUT_W'({r_out_h, r_out_y, r_out_x});
    assign w_out_load  = (r_state == S_DONE) && (!r_m_tvalid || i_m_tready);

    // Wheel difference and wheel sum.
    assign w_diff = DIFF_W'(r_right) - DIFF_W'(r_left);
    assign w_sum  = DIFF_W'(r_right) + DIFF_W'(r_left);

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            S_MUL_X: begin
                w_mul_a = w_sum;
                w_mul_b = MUL_B_W'(r_cx);
            end
            S_MUL_Y: begin
                w_mul_a = w_sum;
                w_mul_b = MUL_B_W'(r_cy);
            end
            default: begin
                w_mul_a = w_diff;
                w_mul_b = signed'({2'b00, r_turn});
            end
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // Heading change, half change and midpoint heading, all rounded to nearest.
    assign w_dth_sum  = r_prod + RND_DTH;
    assign w_half_sum = r_prod + RND_HALF;
    assign w_dth      = w_dth_sum[16+HEADING_W-1:16];
    assign w_half     = w_half_sum[17+HEADING_W-1:17];
    assign w_mid      = r_heading + w_half;

    // Displacement from the registered product and the saturating position add.
    assign w_disp_sum = r_prod + RND_DISP;
    assign w_disp     = w_disp_sum[PROD_W-1:31];
    assign w_acc_in   = (r_state == S_MUL_Y) ? r_x : r_y;
    assign w_sat_sum  = {w_acc_in[POSITION_WIDTH-1], w_acc_in} + (POSITION_WIDTH+1)'(w_disp);
    always_comb begin
        if (w_sat_sum[POSITION_WIDTH] != w_sat_sum[POSITION_WIDTH-1]) begin
            w_sat = w_sat_sum[POSITION_WIDTH] ? POS_MIN : POS_MAX;
        end else begin
            w_sat = w_sat_sum[POSITION_WIDTH-1:0];
        end
    end

    // Shared CORDIC shift-add unit: one rotation per cycle.
    assign w_xs   = r_cx >>> r_step;
    assign w_ys   = r_cy >>> r_step;
    assign w_atan = atan_angle(ATAN_IDX_W'(r_step));

    // Map the first-quadrant result back to the full circle.
    always_comb begin
        case (r_quad)
            2'd0: begin
                w_cos = r_cx;
                w_sin = r_cy;
            end
            2'd1: begin
                w_cos = -r_cy;
                w_sin = r_cx;
            end
            2'd2: begin
                w_cos = -r_cx;
                w_sin = -r_cy;
            end
            default: begin
                w_cos = r_cy;
                w_sin = -r_cx;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_s_tvalid) n_state = S_MUL_TURN;
            S_MUL_TURN: n_state = S_ANGLE;
            S_ANGLE:    n_state = S_ROTATE;
            S_ROTATE:   if (r_step == LAST_STEP) n_state = S_MAP;
            S_MAP:      n_state = S_MUL_X;
            S_MUL_X:    n_state = S_MUL_Y;
            S_MUL_Y:    n_state = S_ACC_Y;
            S_ACC_Y:    n_state = S_DONE;
            S_DONE:     if (w_out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control state, pose accumulators and the configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_turn     <= TURN_RESET;
            r_heading  <= '0;
            r_x        <= '0;
            r_y        <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_turn <= i_cfg_data;
            end
            if (r_state == S_ANGLE) begin
                r_heading <= r_heading + w_dth;
            end
            if (r_state == S_MUL_Y) begin
                r_x <= w_sat;
            end
            if (r_state == S_ACC_Y) begin
                r_y <= w_sat;
            end
            if (w_out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Datapath registers of the shared units.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    r_left  <= i_s_tdata[IN_W-1:0];
                    r_right <= i_s_tdata[2*IN_W-1:IN_W];
                end
            end
            S_MUL_TURN: begin
                r_prod <= w_mul;
            end
            S_ANGLE: begin
                r_quad <= w_mid[HEADING_W-1:HEADING_W-2];
                r_cz   <= signed'({3'b000, w_mid[HEADING_W-3:0]});
                r_cx   <= CORDIC_GAIN;
                r_cy   <= '0;
                r_step <= '0;
            end
            S_ROTATE: begin
                if (!r_cz[TRIG_W-1]) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + w_atan;
                end
                r_step <= r_step + 1'b1;
            end
            S_MAP: begin
                r_cx <= w_cos;
                r_cy <= w_sin;
            end
            S_MUL_X, S_MUL_Y: begin
                r_prod <= w_mul;
            end
            S_DONE: begin
                if (w_out_load) begin
                    r_out_x <= r_x;
                    r_out_y <= r_y;
                    r_out_h <= r_heading;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/ddo_checker.sv =====
// Port-level checker of the odometry block and its bind to the top level.
`include "differential_drive_odometry_assert.svh"

module ddo_checker #(
    parameter int POSITION_WIDTH = ddo_pkg::DEFAULT_POSITION_WIDTH
) (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      i_s_tvalid,
    input logic                                      o_s_tready,
    input logic                                      o_m_tvalid,
    input logic                                      i_m_tready,
    input logic [((2*POSITION_WIDTH+ddo_pkg::HEADING_W+7)/8)*8-1:0] o_m_tdata
);
    import ddo_pkg::*;

    // An accepted transaction keeps the input side busy while the sequencer passes S_MUL_TURN and S_ANGLE.
    `DDO_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready ##1 !o_s_tready)

    // When a new result appears, the sequencer has freed the input side.
    `DDO_ASSERT_NOW(a_result_frees_input, i_clk, i_rst_n, $rose(o_m_tvalid), o_s_tready)

    // A stalled result stays valid and unchanged.
    `DDO_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

endmodule

bind differential_drive_odometry ddo_checker #(
    .POSITION_WIDTH(POSITION_WIDTH)
) u_ddo_checker (.*);

// ===== verif/odometry_checker.sv =====
// Pose predictor and result checker for the differential drive odometry block.
`timescale 1ns / 1ps

module odometry_checker #(
    parameter int POSITION_WIDTH = ddo_pkg::DEFAULT_POSITION_WIDTH,
    parameter int CORDIC_STEPS   = ddo_pkg::DEFAULT_CORDIC_STEPS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Wheel travel stream. tdata: left_distance [17:0], right_distance [35:18], zero fill.
    input  logic                                   i_s_tvalid,
    input  logic                                   i_s_tready,
    input  logic [ddo_pkg::IN_TDATA_W-1:0]         i_s_tdata,
    // Pose stream. tdata: pos_x, pos_y, heading from the lowest bit up.
    input  logic                                   i_m_tvalid,
    input  logic                                   i_m_tready,
    input  logic [((2*POSITION_WIDTH+ddo_pkg::HEADING_W+7)/8)*8-1:0] i_m_tdata,
    // Turn rate write channel.
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [ddo_pkg::HEADING_W-1:0]          i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    // One pose in the layout of the result tdata.
    typedef struct packed {
        logic [ddo_pkg::HEADING_W-1:0] heading;
        logic [POSITION_WIDTH-1:0]     pos_y;
        logic [POSITION_WIDTH-1:0]     pos_x;
    } pose_t;

    localparam longint POS_MAX  = (longint'(1) <<< (POSITION_WIDTH - 1)) - 1;
    localparam longint POS_MIN  = -POS_MAX - 1;
    localparam longint UNIT_Q30 = 64'sd652032874;

    // Quadrant selected by the top two bits of the midpoint angle.
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    logic [31:0] turn_rate;
    logic [31:0] heading_now;
    longint      x_now;
    longint      y_now;
    pose_t       expected_poses[$];
    pose_t       seen_pose;
    pose_t       due_pose;
    int          fail_total = 0;

    // Arctangent of 2^-i as a binary angle.
    function automatic longint rotation_angle(input int idx);
        case (idx)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            23: return 81;
            24: return 41;
            25: return 20;
            26: return 10;
            27: return 5;
            28: return 3;
            29: return 1;
            30: return 1;
            default: return 0;
        endcase
    endfunction

    // Adds a displacement and clamps at the ends of the position range.
    function automatic longint clamp_add(input longint acc, input longint step);
        if (step > 0 && acc > POS_MAX - step) return POS_MAX;
        if (step < 0 && acc < POS_MIN - step) return POS_MIN;
        return acc + step;
    endfunction

    // Advances the predicted pose by one wheel travel item and queues the new pose.
    task automatic advance_pose(input logic signed [17:0] left, input logic signed [17:0] right);
        longint      turn_prod;
        longint      dth;
        longint      half;
        longint      cx;
        longint      cy;
        longint      cz;
        longint      xs;
        longint      ys;
        longint      cosv;
        longint      sinv;
        longint      travel;
        logic [31:0] mid;
        int          i;
        pose_t       nxt;

        turn_prod = (longint'(right) - longint'(left)) * longint'({32'd0, turn_rate});
        dth  = (turn_prod + 64'sd32768) >>> 16;
        half = (turn_prod + 64'sd65536) >>> 17;
        mid  = heading_now + half[31:0];

        // Rotate the unit vector through the angle within the quadrant.
        cx = UNIT_Q30;
        cy = 0;
        cz = longint'({34'd0, mid[29:0]});
        for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cz >= 0) begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - rotation_angle(i);
            end else begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + rotation_angle(i);
            end
        end

        // Map the result back to the full circle.
        case (mid[31:30])
            QUAD_FIRST: begin
                cosv = cx;
                sinv = cy;
            end
            QUAD_SECOND: begin
                cosv = -cy;
                sinv = cx;
            end
            QUAD_THIRD: begin
                cosv = -cx;
                sinv = -cy;
            end
            default: begin
                cosv = cy;
                sinv = -cx;
            end
        endcase

        travel      = longint'(left) + longint'(right);
        heading_now = heading_now + dth[31:0];
        x_now = clamp_add(x_now, (travel * cosv + 64'sd1073741824) >>> 31);
        y_now = clamp_add(y_now, (travel * sinv + 64'sd1073741824) >>> 31);

        nxt.pos_x   = x_now[POSITION_WIDTH-1:0];
        nxt.pos_y   = y_now[POSITION_WIDTH-1:0];
        nxt.heading = heading_now;
        expected_poses.push_back(nxt);
    endtask

    // Watch all three channels. Results are checked before the same edge's input is
    // predicted, since a result can never belong to an input taken at that edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            turn_rate   = ddo_pkg::TURN_RESET;
            heading_now = '0;
            x_now       = 0;
            y_now       = 0;
            expected_poses.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_poses.size() == 0) begin
                    $error("pose transaction arrived with no expected pose waiting");
                    fail_total++;
                end else begin
                    seen_pose = i_m_tdata;
                    due_pose  = expected_poses.pop_front();
                    if (seen_pose.pos_x !== due_pose.pos_x) begin
                        $error("pos_x mismatch: expected %0d, actual %0d",
                               $signed(due_pose.pos_x), $signed(seen_pose.pos_x));
                        fail_total++;
                    end
                    if (seen_pose.pos_y !== due_pose.pos_y) begin
                        $error("pos_y mismatch: expected %0d, actual %0d",
                               $signed(due_pose.pos_y), $signed(seen_pose.pos_y));
                        fail_total++;
                    end
                    if (seen_pose.heading !== due_pose.heading) begin
                        $error("heading mismatch: expected %0d, actual %0d",
                               due_pose.heading, seen_pose.heading);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                turn_rate = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_pose(i_s_tdata[17:0], i_s_tdata[35:18]);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_poses.size();
    end

endmodule

// ===== verif/differential_drive_odometry_tb.sv =====
// Top level testbench of the odometry block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module differential_drive_odometry_tb;

    localparam int POS_W           = ddo_pkg::DEFAULT_POSITION_WIDTH;
    localparam int RES_W           = ((2 * POS_W + ddo_pkg::HEADING_W + 7) / 8) * 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES   = 40;

    // Idle patterns of the two stream sides.
    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_s_tvalid  = 1'b0;
    logic                             o_s_tready;
    logic [ddo_pkg::IN_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready  = 1'b0;
    logic [RES_W-1:0]                 o_m_tdata;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [ddo_pkg::HEADING_W-1:0]    i_cfg_data  = '0;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int ready_hold     = 0;

    always #5 i_clk = ~i_clk;

    differential_drive_odometry uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    odometry_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: ready comes in bursts so that stalls of several cycles occur.
    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_hold <= $urandom_range(1, 12);
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // Selects how often each side idles.
    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FULL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SENDER_IDLE: begin
                send_idle_pct  = 65;
                recv_stall_pct = 0;
            end
            PACE_RECEIVER_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 65;
            end
            default: begin
                send_idle_pct  = 32;
                recv_stall_pct = 32;
            end
        endcase
    endtask

    // Offers one wheel travel item, after a random gap, and waits for its transaction.
    task automatic send_item(input int left, input int right);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(ddo_pkg::IN_TDATA_W - 36){1'b0}}, right[17:0], left[17:0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Stops the input stream and waits until every expected pose has come out.
    task automatic drain;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Writes the turn rate once the block has gone idle.
    task automatic write_turn(input logic [31:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus.
    initial begin
        int    left;
        int    right;
        int    mix;
        int    span;
        logic [31:0] turn_value;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset turn rate: range ends, pure turns, straight runs
        // and raw 18-bit patterns outside the nominal range. Position saturation needs
        // far more steps than a run can take, so it is not reached from reset.
        set_pace(PACE_FULL);
        send_item(0, 0);
        send_item(65536, 65536);
        send_item(-65536, -65536);
        send_item(65536, -65536);
        send_item(-65536, 65536);
        send_item(0, 65536);
        send_item(65536, 0);
        send_item(-65536, 0);
        send_item(0, -65536);
        send_item(1, -1);
        send_item(-1, 1);
        send_item(131071, 131071);
        send_item(-131072, -131072);
        send_item(131071, -131072);
        send_item(-131072, 131071);
        send_item(-1, -1);
        // Repeated full spins drive the heading across its wrap point.
        repeat (6) send_item(-65536, 65536);
        repeat (3) send_item(65536, -65536);

        // Random phases: each starts with a new turn rate and cycles the idle pattern.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       turn_value = 32'hFFFF_FFFF;
                1:       turn_value = 32'd0;
                2:       turn_value = 32'd1;
                3:       turn_value = ddo_pkg::TURN_RESET;
                default: turn_value = $urandom();
            endcase
            write_turn(turn_value);
            set_pace(pace_t'(phase % 4));

            repeat (ITEMS_PER_PHASE) begin
                mix = $urandom_range(99);
                if (mix < 10) begin
                    // Any 18-bit pattern.
                    left  = $urandom_range(262143);
                    right = $urandom_range(262143);
                end else if (mix < 25) begin
                    // Straight run.
                    left  = int'($urandom_range(131072)) - 65536;
                    right = left;
                end else if (mix < 35) begin
                    // Turn in place.
                    left  = int'($urandom_range(131072)) - 65536;
                    right = -left;
                end else if (mix < 50) begin
                    // Slow creeping motion.
                    span  = 256;
                    left  = int'($urandom_range(2 * span)) - span;
                    right = int'($urandom_range(2 * span)) - span;
                end else begin
                    left  = int'($urandom_range(131072)) - 65536;
                    right = int'($urandom_range(131072)) - 65536;
                end
                send_item(left, right);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ddo_pkg.sv
rtl/core/differential_drive_odometry.sv
rtl/core/ddo_checker.sv
verif/odometry_checker.sv
verif/differential_drive_odometry_tb.sv
